// File: rtl/core/dhpg_pkg.sv
`default_nettype none

package dhpg_pkg;

   localparam int TIME_WIDTH_DEFAULT = 48;

   localparam int SESSION_WIDTH  = 64;
   localparam int SEQUENCE_WIDTH = 32;
   localparam int REVISION_WIDTH = 32;
   localparam int STATE_WIDTH    = 3;
   localparam int FOV_WIDTH      = 32;
   localparam int OFFER_FOV_W    = 19;
   localparam int WINDOW_WIDTH   = 48;
   localparam int DECISION_WIDTH = 2;

   localparam int DATA_WIDTH = 64;
   localparam int ADDR_WIDTH = 6;
   localparam int REG_IDX_W  = 3;

   localparam logic [FOV_WIDTH-1:0]    MAX_APPLIED_FOV = 32'd360000;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET    = 48'd1000000;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam logic [STATE_WIDTH-1:0] CS_WORLD      = 3'd0;
   localparam logic [STATE_WIDTH-1:0] CS_LAST_LEGAL = 3'd3;

   localparam logic [DECISION_WIDTH-1:0] DEC_COMFORT   = 2'd0;
   localparam logic [DECISION_WIDTH-1:0] DEC_WAIT      = 2'd1;
   localparam logic [DECISION_WIDTH-1:0] DEC_IMMERSIVE = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_OFFER_VALID  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SESSION_HIGH = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SESSION_LOW  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_REVISION     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FOV          = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW       = 3'd5;

   typedef struct packed {
      logic                      offer_valid;
      logic [SESSION_WIDTH-1:0]  expected_session_high;
      logic [SESSION_WIDTH-1:0]  expected_session_low;
      logic [REVISION_WIDTH-1:0] expected_revision;
      logic [OFFER_FOV_W-1:0]    expected_fov_milli;
      logic [WINDOW_WIDTH-1:0]   freshness_window;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/core/dhpg_req_if.sv
`default_nettype none

interface dhpg_req_if #(
   parameter int TIME_WIDTH = 48
);
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [TIME_WIDTH-1:0] event_time;
   logic [63:0]           reply_session_high;
   logic [63:0]           reply_session_low;
   logic [31:0]           reply_sequence;
   logic [31:0]           reply_revision;
   logic [2:0]            client_state;
   logic [31:0]           applied_fov_milli;
   logic                  capture_present;
   logic [TIME_WIDTH-1:0] capture_time;

   modport source (
      output valid, kind, event_time, reply_session_high, reply_session_low,
             reply_sequence, reply_revision, client_state, applied_fov_milli,
             capture_present, capture_time,
      input  ready
   );

   modport sink (
      input  valid, kind, event_time, reply_session_high, reply_session_low,
             reply_sequence, reply_revision, client_state, applied_fov_milli,
             capture_present, capture_time,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/dhpg_rsp_if.sv
`default_nettype none

interface dhpg_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic [1:0] decision;

   modport source (
      output valid, accepted, decision,
      input  ready
   );

   modport sink (
      input  valid, accepted, decision,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/dhpg_csr.sv
`default_nettype none

module dhpg_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [dhpg_pkg::ADDR_WIDTH-1:0]  paddr,
   input  wire logic [dhpg_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic      [dhpg_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                                  pready,
   output dhpg_pkg::cfg_type                     cfg
);
   import dhpg_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 write_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign reg_idx  = paddr[ADDR_WIDTH-1:ADDR_WIDTH-REG_IDX_W];
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_idx)
            REG_OFFER_VALID:  cfg_in.offer_valid           = pwdata[0];
            REG_SESSION_HIGH: cfg_in.expected_session_high = pwdata;
            REG_SESSION_LOW:  cfg_in.expected_session_low  = pwdata;
            REG_REVISION:     cfg_in.expected_revision     = pwdata[REVISION_WIDTH-1:0];
            REG_FOV:          cfg_in.expected_fov_milli    = pwdata[OFFER_FOV_W-1:0];
            REG_WINDOW:       cfg_in.freshness_window      = pwdata[WINDOW_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OFFER_VALID:  prdata = DATA_WIDTH'(cfg_ff.offer_valid);
         REG_SESSION_HIGH: prdata = cfg_ff.expected_session_high;
         REG_SESSION_LOW:  prdata = cfg_ff.expected_session_low;
         REG_REVISION:     prdata = DATA_WIDTH'(cfg_ff.expected_revision);
         REG_FOV:          prdata = DATA_WIDTH'(cfg_ff.expected_fov_milli);
         REG_WINDOW:       prdata = DATA_WIDTH'(cfg_ff.freshness_window);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offer_valid           <= 1'b0;
         cfg_ff.expected_session_high <= '0;
         cfg_ff.expected_session_low  <= '0;
         cfg_ff.expected_revision     <= '0;
         cfg_ff.expected_fov_milli    <= '0;
         cfg_ff.freshness_window      <= WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/dhpg_gate.sv
`default_nettype none

module dhpg_gate #(
   parameter int TIME_WIDTH = dhpg_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire dhpg_pkg::cfg_type                    cfg,
   input  wire logic                                 fire,
   input  wire logic                                 kind,
   input  wire logic [TIME_WIDTH-1:0]                event_time,
   input  wire logic [dhpg_pkg::SESSION_WIDTH-1:0]   reply_session_high,
   input  wire logic [dhpg_pkg::SESSION_WIDTH-1:0]   reply_session_low,
   input  wire logic [dhpg_pkg::SEQUENCE_WIDTH-1:0]  reply_sequence,
   input  wire logic [dhpg_pkg::REVISION_WIDTH-1:0]  reply_revision,
   input  wire logic [dhpg_pkg::STATE_WIDTH-1:0]     client_state,
   input  wire logic [dhpg_pkg::FOV_WIDTH-1:0]       applied_fov_milli,
   input  wire logic                                 capture_present,
   input  wire logic [TIME_WIDTH-1:0]                capture_time,
   output logic                                      accepted,
   output logic      [dhpg_pkg::DECISION_WIDTH-1:0]  decision
);
   import dhpg_pkg::*;

   localparam int CMP_W = (TIME_WIDTH > WINDOW_WIDTH) ? TIME_WIDTH : WINDOW_WIDTH;

   logic                      has_state_ff,     has_state_in;
   logic [1:0]                current_state_ff, current_state_in;
   logic                      has_heartbeat_ff, has_heartbeat_in;
   logic [TIME_WIDTH-1:0]     heartbeat_time_ff, heartbeat_time_in;
   logic                      has_barrier_ff,   has_barrier_in;
   logic [TIME_WIDTH-1:0]     barrier_time_ff,  barrier_time_in;
   logic                      has_sequence_ff,  has_sequence_in;
   logic [SEQUENCE_WIDTH-1:0] last_sequence_ff, last_sequence_in;

   logic                  time_back;
   logic [TIME_WIDTH-1:0] age;
   logic                  stale;
   logic                  report_ok;
   logic                  moved;
   logic                  take_report;

   assign time_back = has_heartbeat_ff && (event_time < heartbeat_time_ff);
   assign age       = event_time - heartbeat_time_ff;
   assign stale     = CMP_W'(age) > CMP_W'(cfg.freshness_window);

   assign report_ok = cfg.offer_valid
                   && (reply_session_high == cfg.expected_session_high)
                   && (reply_session_low == cfg.expected_session_low)
                   && (reply_revision == cfg.expected_revision)
                   && (client_state <= CS_LAST_LEGAL)
                   && (applied_fov_milli <= MAX_APPLIED_FOV)
                   && !(client_state == CS_WORLD
                        && applied_fov_milli != FOV_WIDTH'(cfg.expected_fov_milli))
                   && !(has_sequence_ff && reply_sequence <= last_sequence_ff)
                   && !time_back;

   assign moved = !has_state_ff || (current_state_ff != client_state[1:0])
               || (has_heartbeat_ff && stale);

   assign take_report = fire && (kind == KIND_REPORT) && report_ok;

   always_comb begin
      accepted = 1'b0;
      decision = DEC_COMFORT;
      if (kind == KIND_REPORT) begin
         accepted = report_ok;
      end else if (!has_state_ff || !has_heartbeat_ff || !has_barrier_ff
                   || event_time < heartbeat_time_ff || stale) begin
         decision = DEC_COMFORT;
      end else if (!capture_present || capture_time <= barrier_time_ff) begin
         decision = DEC_WAIT;
      end else if (current_state_ff == CS_WORLD[1:0]) begin
         decision = DEC_IMMERSIVE;
      end
   end

   always_comb begin
      has_state_in      = has_state_ff;
      current_state_in  = current_state_ff;
      has_heartbeat_in  = has_heartbeat_ff;
      heartbeat_time_in = heartbeat_time_ff;
      has_barrier_in    = has_barrier_ff;
      barrier_time_in   = barrier_time_ff;
      has_sequence_in   = has_sequence_ff;
      last_sequence_in  = last_sequence_ff;
      if (take_report) begin
         has_state_in      = 1'b1;
         current_state_in  = client_state[1:0];
         has_heartbeat_in  = 1'b1;
         heartbeat_time_in = event_time;
         has_sequence_in   = 1'b1;
         last_sequence_in  = reply_sequence;
         if (moved) begin
            has_barrier_in  = 1'b1;
            barrier_time_in = event_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_state_ff      <= 1'b0;
         current_state_ff  <= '0;
         has_heartbeat_ff  <= 1'b0;
         heartbeat_time_ff <= '0;
         has_barrier_ff    <= 1'b0;
         barrier_time_ff   <= '0;
         has_sequence_ff   <= 1'b0;
         last_sequence_ff  <= '0;
      end else begin
         has_state_ff      <= has_state_in;
         current_state_ff  <= current_state_in;
         has_heartbeat_ff  <= has_heartbeat_in;
         heartbeat_time_ff <= heartbeat_time_in;
         has_barrier_ff    <= has_barrier_in;
         barrier_time_ff   <= barrier_time_in;
         has_sequence_ff   <= has_sequence_in;
         last_sequence_ff  <= last_sequence_in;
      end
   end

   a_barrier_with_state: assert property (@(posedge clock) disable iff (reset)
      has_barrier_ff == has_state_ff)
      else $error("Barrier and state presence disagree.");

   a_barrier_not_ahead: assert property (@(posedge clock) disable iff (reset)
      has_barrier_ff |-> barrier_time_ff <= heartbeat_time_ff)
      else $error("Transition barrier lies after the last heartbeat.");

   a_sequence_rises: assert property (@(posedge clock) disable iff (reset)
      take_report && has_sequence_ff |=> last_sequence_ff > $past(last_sequence_ff))
      else $error("Accepted report did not raise the sequence number.");

endmodule

`default_nettype wire

// File: rtl/core/display_heartbeat_presentation_gate_unit.sv
`default_nettype none

// Presentation gate for a display client. Each request word is either a state report
// or a presentation query and yields exactly one response word, in order. A word is
// registered on entry, evaluated against the tracked client state from that input
// register once the response register is empty or being drained, and then written to
// the response register; a full response register that is not taken stalls the word.
// One word is taken in every cycle while responses are drained.
// Reports update the tracked state as they pass evaluation, so a query sees every
// report accepted before it. Configuration registers sit at byte address 8*i and
// should only be written while no word is in flight.
module display_heartbeat_presentation_gate_unit #(
   parameter int TIME_WIDTH = dhpg_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   dhpg_req_if.sink                              req_ch,
   dhpg_rsp_if.source                            rsp_ch,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [dhpg_pkg::ADDR_WIDTH-1:0]  paddr,
   input  wire logic [dhpg_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic      [dhpg_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                                  pready
);
   import dhpg_pkg::*;

   cfg_type cfg;

   logic                      item_valid_ff, item_valid_in;
   logic                      kind_ff;
   logic [TIME_WIDTH-1:0]     event_time_ff;
   logic [SESSION_WIDTH-1:0]  session_high_ff;
   logic [SESSION_WIDTH-1:0]  session_low_ff;
   logic [SEQUENCE_WIDTH-1:0] sequence_ff;
   logic [REVISION_WIDTH-1:0] revision_ff;
   logic [STATE_WIDTH-1:0]    client_state_ff;
   logic [FOV_WIDTH-1:0]      fov_ff;
   logic                      capture_present_ff;
   logic [TIME_WIDTH-1:0]     capture_time_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accepted_ff;
   logic [DECISION_WIDTH-1:0] decision_ff;

   logic                      advance;
   logic                      take_in;
   logic                      accepted_in;
   logic [DECISION_WIDTH-1:0] decision_in;

   assign advance      = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;
   assign take_in      = req_ch.valid && req_ch.ready;

   assign item_valid_in = take_in || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ch.ready);

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.accepted = accepted_ff;
   assign rsp_ch.decision = decision_ff;

   dhpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dhpg_gate #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_gate (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .fire               (advance),
      .kind               (kind_ff),
      .event_time         (event_time_ff),
      .reply_session_high (session_high_ff),
      .reply_session_low  (session_low_ff),
      .reply_sequence     (sequence_ff),
      .reply_revision     (revision_ff),
      .client_state       (client_state_ff),
      .applied_fov_milli  (fov_ff),
      .capture_present    (capture_present_ff),
      .capture_time       (capture_time_ff),
      .accepted           (accepted_in),
      .decision           (decision_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         kind_ff            <= req_ch.kind;
         event_time_ff      <= req_ch.event_time;
         session_high_ff    <= req_ch.reply_session_high;
         session_low_ff     <= req_ch.reply_session_low;
         sequence_ff        <= req_ch.reply_sequence;
         revision_ff        <= req_ch.reply_revision;
         client_state_ff    <= req_ch.client_state;
         fov_ff             <= req_ch.applied_fov_milli;
         capture_present_ff <= req_ch.capture_present;
         capture_time_ff    <= req_ch.capture_time;
      end
      if (advance) begin
         accepted_ff <= accepted_in;
         decision_ff <= decision_in;
      end
   end

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("Evaluated word did not reach the response register.");

   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff)
      else $error("Input stage word lost while stalled.");

   a_exclusive_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(accepted_ff && decision_ff != DEC_COMFORT))
      else $error("Response carries both an acceptance and a decision.");

   a_decision_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (decision_ff == DEC_COMFORT || decision_ff == DEC_WAIT
                        || decision_ff == DEC_IMMERSIVE))
      else $error("Response decision code is undefined.");

endmodule

`default_nettype wire
